>>> sv/fraction_add_reduce_macros.svh
// Assertion macros shared by the checker
`ifndef FRACTION_ADD_REDUCE_MACROS_SVH
`define FRACTION_ADD_REDUCE_MACROS_SVH
// Implication checked on every clock, masked during reset
`define FAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fraction_add_reduce check failed");
// Next-cycle implication, masked during reset
`define FAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fraction_add_reduce check failed");
`endif

>>> sv/far_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_pkg
// Types and constants of the fraction adder.
// ----------------------------------------------------------------------------
package far_pkg;
    localparam int WordW = 64;
    typedef logic [WordW-1:0] t_word;
    typedef logic [6:0]       t_bitcnt;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G1_DIV,    // gcd(b, d)
        ST_LCM_DIV,   // b / g
        ST_LCM_MUL,   // (b/g) * d
        ST_SA_DIV,    // den / b
        ST_SA_MUL,    // a * (den/b)
        ST_SC_DIV,    // den / d
        ST_SC_MUL,    // c * (den/d)
        ST_G2_PREP,
        ST_G2_DIV,    // gcd(mag, den)
        ST_R1_DIV,    // mag / g
        ST_R2_DIV,    // den / g
        ST_OUT
    } t_state;

    // divider request/response
    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quot;
        t_word rem;
    } t_div_rsp;
endpackage

>>> sv/far_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module far_div
    import far_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    t_word   r_q, n_q, r_rem, n_rem, r_dvs;
    t_bitcnt r_cnt;
    logic    r_busy, r_done;
    logic [WordW:0] w_trial;

    // one step: shift in next dividend bit, try subtract
    always_comb begin
        w_trial = {r_rem, r_q[WordW-1]} - {1'b0, r_dvs};
        if (!w_trial[WordW]) begin
            n_rem = w_trial[WordW-1:0];
            n_q   = {r_q[WordW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[WordW-2:0], r_q[WordW-1]};
            n_q   = {r_q[WordW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(WordW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;
endmodule

>>> sv/fraction_add_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two signed fractions and returns the sum in lowest terms.
// ----------------------------------------------------------------------------
// One request at a time. All divisions and gcd remainders run on one shared
// divider. A request runs the first gcd, the lcm, the scaling, the second gcd
// and the two reductions in the normal case; a pass through skips the first
// gcd, the lcm and the scaling. The result waits in the output register until
// taken; the next request is accepted meanwhile, and a newer result holds in
// the last state until the register frees.
module fraction_add_reduce
    import far_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_num[31:0], first_den[62:32], second_num[94:63], second_den[125:95]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sum_num[63:0], sum_den[126:64]
    output logic [127:0] m_axis_tdata
);
    t_state r_st, n_st;
    t_word  r_a, r_b, r_c, r_d, r_x, r_y, r_num, r_den, r_mag, r_g;
    logic   r_neg, r_ovld;
    logic   r_go, n_go;
    logic [126:0] r_out;
    logic   w_a_empty, w_c_empty;
    t_div_req w_req;
    t_div_rsp w_rsp;
    logic signed [31:0] r_ma;
    logic        [31:0] r_mb;
    logic signed [63:0] w_prod;

    far_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // 32x32 signed by unsigned multiply (factors fit in 32 bits)
    assign w_prod = r_ma * $signed({1'b0, r_mb});

    // empty operands of the incoming request
    assign w_a_empty = (s_axis_tdata[31:0] == '0) || (s_axis_tdata[62:32] == '0);
    assign w_c_empty = (s_axis_tdata[94:63] == '0) || (s_axis_tdata[125:95] == '0);

    assign s_axis_tready = (r_st == ST_IDLE);

    // sequencer: next state and divider launches
    always_comb begin
        n_st = r_st;
        n_go = 1'b0;
        case (r_st)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                if (w_a_empty || w_c_empty) begin
                    n_st = ST_G2_PREP;
                end else begin
                    n_st = ST_G1_DIV;
                    n_go = 1'b1;
                end
            end
            ST_G1_DIV, ST_G2_DIV: if (w_rsp.done) begin
                n_go = 1'b1;
                if (w_rsp.rem == '0)
                    n_st = (r_st == ST_G1_DIV) ? ST_LCM_DIV : ST_R1_DIV;
            end
            ST_LCM_DIV: if (w_rsp.done) n_st = ST_LCM_MUL;
            ST_LCM_MUL: begin
                n_st = ST_SA_DIV;
                n_go = 1'b1;
            end
            ST_SA_DIV:  if (w_rsp.done) n_st = ST_SA_MUL;
            ST_SA_MUL: begin
                n_st = ST_SC_DIV;
                n_go = 1'b1;
            end
            ST_SC_DIV:  if (w_rsp.done) n_st = ST_SC_MUL;
            ST_SC_MUL:  n_st = ST_G2_PREP;
            ST_G2_PREP: begin
                if (r_den == '0) begin
                    n_st = ST_OUT;
                end else begin
                    n_st = ST_G2_DIV;
                    n_go = 1'b1;
                end
            end
            ST_R1_DIV: if (w_rsp.done) begin
                n_st = ST_R2_DIV;
                n_go = 1'b1;
            end
            ST_R2_DIV:  if (w_rsp.done) n_st = ST_OUT;
            ST_OUT:     if (!r_ovld || m_axis_tready) n_st = ST_IDLE;
            default:    n_st = ST_IDLE;
        endcase
    end

    // state register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_OUT && (!r_ovld || m_axis_tready)) begin
                r_ovld <= 1'b1;
                r_out  <= {r_den[62:0], r_num};
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath and divider operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= n_go;
            case (r_st)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_a <= {{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
                    r_b <= {33'd0, s_axis_tdata[62:32]};
                    r_c <= {{32{s_axis_tdata[94]}}, s_axis_tdata[94:63]};
                    r_d <= {33'd0, s_axis_tdata[125:95]};
                    if (w_a_empty) begin
                        r_num <= {{32{s_axis_tdata[94]}}, s_axis_tdata[94:63]};
                        r_den <= {33'd0, s_axis_tdata[125:95]};
                    end else if (w_c_empty) begin
                        r_num <= {{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
                        r_den <= {33'd0, s_axis_tdata[62:32]};
                    end else begin
                        r_x <= {33'd0, s_axis_tdata[62:32]};
                        r_y <= {33'd0, s_axis_tdata[125:95]};
                    end
                end
                ST_G1_DIV, ST_G2_DIV: if (w_rsp.done) begin
                    if (w_rsp.rem == '0) begin
                        r_g <= r_y;
                        // next: b / g for the lcm, or mag / g for the reduction
                        r_x <= (r_st == ST_G1_DIV) ? r_b : r_mag;
                    end else begin
                        r_x <= r_y;
                        r_y <= w_rsp.rem;
                    end
                end
                ST_LCM_DIV: if (w_rsp.done) begin
                    r_ma <= w_rsp.quot[31:0];
                    r_mb <= r_d[31:0];
                end
                ST_LCM_MUL: begin
                    r_den <= w_prod;
                    r_x   <= w_prod;
                    r_y   <= r_b;
                end
                ST_SA_DIV: if (w_rsp.done) begin
                    r_ma <= r_a[31:0];
                    r_mb <= w_rsp.quot[31:0];
                end
                ST_SA_MUL: begin
                    r_num <= w_prod;
                    r_x   <= r_den;
                    r_y   <= r_d;
                end
                ST_SC_DIV: if (w_rsp.done) begin
                    r_ma <= r_c[31:0];
                    r_mb <= w_rsp.quot[31:0];
                end
                ST_SC_MUL: r_num <= r_num + w_prod;
                ST_G2_PREP: begin
                    r_neg <= r_num[63];
                    r_mag <= r_num[63] ? (t_word'(0) - r_num) : r_num;
                    if (r_den == '0) begin
                        // gcd(mag, 0) = mag: reduce to sign/0 unless mag is zero
                        r_num <= (r_num == '0) ? '0 : (r_num[63] ? '1 : t_word'(1));
                    end else begin
                        r_x <= r_num[63] ? (t_word'(0) - r_num) : r_num;
                        r_y <= r_den;
                    end
                end
                ST_R1_DIV: if (w_rsp.done) begin
                    r_num <= r_neg ? (t_word'(0) - w_rsp.quot) : w_rsp.quot;
                    r_x   <= r_den;
                    r_y   <= r_g;
                end
                ST_R2_DIV: if (w_rsp.done) r_den <= w_rsp.quot;
                default: ;
            endcase
        end
    end

    // divide start is registered alongside the operands, so both arrive together
    always_comb begin
        w_req.start    = r_go;
        w_req.dividend = r_x;
        w_req.divisor  = r_y;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {1'b0, r_out};
endmodule

>>> sv/far_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_checker
// Port-level checks of the fraction adder.
// ----------------------------------------------------------------------------
`include "fraction_add_reduce_macros.svh"
module far_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    `FAR_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FAR_ASSERT_IMPL(a_flags_known, i_clk, i_rst_n, 1'b1, !$isunknown({s_axis_tready, m_axis_tvalid}))
    `FAR_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `FAR_ASSERT_IMPL(a_den_top_zero, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[127])
endmodule

bind fraction_add_reduce far_checker u_far_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> sim/tb_fraction_add_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_add_reduce
// Drives fraction pairs into the adder and checks each reduced sum against
// a behavioral prediction kept in a scoreboard, with random input gaps and
// random output stalls.
// ----------------------------------------------------------------------------

// Predicts reduced sums and matches them against the block's results
class sum_scoreboard;
    bit [126:0] pending_sums[$];
    int         errors;

    static function bit [63:0] euclid(bit [63:0] x, bit [63:0] y);
        bit [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // note an accepted request and queue its expected sum
    function void note_request(bit [127:0] req);
        bit [63:0] a, b, c, d, num, den, mag, g, gd;
        bit        neg;
        a = {{32{req[31]}}, req[31:0]};
        b = {33'd0, req[62:32]};
        c = {{32{req[94]}}, req[94:63]};
        d = {33'd0, req[125:95]};
        if (a == 0 || b == 0) begin
            num = c;
            den = d;
        end else if (c == 0 || d == 0) begin
            num = a;
            den = b;
        end else begin
            gd  = euclid(b, d);
            den = (b / gd) * d;
            num = a * (den / b) + c * (den / d);
        end
        neg = num[63];
        mag = neg ? -num : num;
        g   = euclid(mag, den);
        if (g != 0) begin
            mag = mag / g;
            den = den / g;
        end
        num = neg ? -mag : mag;
        pending_sums.push_back({den[62:0], num});
    endfunction

    // compare one result with the oldest expectation
    function void check_result(bit [127:0] rsp);
        bit [126:0] exp_sum;
        if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result num=%0d den=%0d", $time,
                     $signed(rsp[63:0]), rsp[126:64]);
            errors++;
            return;
        end
        exp_sum = pending_sums.pop_front();
        if (rsp[63:0] !== exp_sum[63:0]) begin
            $display("%0t: sum_num expected %0d actual %0d", $time,
                     $signed(exp_sum[63:0]), $signed(rsp[63:0]));
            errors++;
        end
        if (rsp[126:64] !== exp_sum[126:64]) begin
            $display("%0t: sum_den expected %0d actual %0d", $time,
                     exp_sum[126:64], rsp[126:64]);
            errors++;
        end
    endfunction
endclass

module tb_fraction_add_reduce;
    localparam int RandCount  = 450;
    localparam int StallLimit = 200000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // first_num, first_den, second_num, second_den from bit 0 up
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // sum_num, sum_den from bit 0 up
    logic [127:0] m_axis_tdata;

    sum_scoreboard sb = new();
    int            idle_cycles = 0;

    fraction_add_reduce uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // send one request and hold it until accepted
    task automatic send_fraction_pair(bit [31:0] a, bit [30:0] b, bit [31:0] c,
                                      bit [30:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, d, c, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request({2'b00, d, c, b, a});
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic bit [31:0] rand_num();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'($urandom_range(0, 40) - 20);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic bit [30:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 31'h7fff_ffff;
            1: return 31'd0;
            2: return 31'($urandom_range(1, 64));
            default: return 31'($urandom);
        endcase
    endfunction

    // receiver stall pattern: ready drawn at random, high with a 5 in 8 chance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 7) < 5);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // watchdog on cycles without any accepted request or taken result
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int burst;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, empty operands, zero sums, degenerate fractions
        send_fraction_pair(32'd1, 31'd2, 32'd1, 31'd3);
        send_fraction_pair(32'd0, 31'd5, 32'd6, 31'd4);
        send_fraction_pair(32'd7, 31'd0, 32'd3, 31'd9);
        send_fraction_pair(32'd4, 31'd6, 32'd0, 31'd3);
        send_fraction_pair(32'd4, 31'd6, 32'd5, 31'd0);
        send_fraction_pair(32'd0, 31'd0, 32'd0, 31'd0);
        send_fraction_pair(32'd0, 31'd0, 32'd0, 31'd8);
        send_fraction_pair(32'd0, 31'd0, -32'sd9, 31'd0);
        send_fraction_pair(32'd0, 31'd0, 32'd9, 31'd0);
        send_fraction_pair(32'd1, 31'd2, -32'sd1, 31'd2);
        send_fraction_pair(32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_fffe);
        send_fraction_pair(32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_fffe);
        send_fraction_pair(32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        send_fraction_pair(32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
        send_fraction_pair(32'hffff_ffff, 31'd3, 32'hffff_ffff, 31'd6);
        send_fraction_pair(-32'sd6, 31'd4, 32'd0, 31'd0);
        send_fraction_pair(32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);

        // random bursts with gaps
        for (int n = 0; n < RandCount; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
                send_fraction_pair(rand_num(), rand_den(), rand_num(), rand_den());
            idle_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_sums.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
